[sv/saod_pkg.sv]
// Shared types, constants and codes of the speech activity onset detector.
package saod_pkg;

   localparam int MAX_CHANNELS_DEF = 8;

   localparam int SAMPLE_W    = 16;
   localparam int CHAN_W      = 3;
   localparam int LEVEL_W     = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;

   localparam int CNT_CFG_W = 4;
   localparam int LOG2_W    = 4;
   localparam int COEF_W    = 16;
   localparam int THR_W     = 31;
   localparam int MAX_LOG2  = 10;

   localparam int SQ_W   = 31;   // square of a Q1.15 sample
   localparam int SUM_W  = 42;   // block sum of squares
   localparam int CNT_W  = 11;   // samples in a block, up to 1024
   localparam int MS_W   = 41;   // mean square after the shift
   localparam int INT_W  = 32;   // stored intensity
   localparam int DEC_W  = 40;   // decay store, signed Q23.16
   localparam int ACC_W  = 58;   // partial-product accumulators
   localparam int MULA_W = 17;
   localparam int MULB_W = 24;
   localparam int PROD_W = MULA_W + MULB_W;
   localparam int STEPS  = 6;    // partial products per channel update

   localparam int FIFO_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAG_LEN_LOG2    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENV_COEF         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONSET_COEF       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_SQ     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSITIONS_ONLY = 3'd5;

   localparam logic [LEVEL_W-1:0] LEVEL_SILENT = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_ACTIVE = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_ONSET  = 2'd2;

   typedef struct packed {
      logic [CNT_CFG_W-1:0] channel_count;
      logic [LOG2_W-1:0]    frag_len_log2;
      logic [COEF_W-1:0]    env_coef;
      logic [COEF_W-1:0]    onset_coef;
      logic [THR_W-1:0]     threshold_sq;
      logic                 transitions_only;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      channel_count:    4'd2,
      frag_len_log2:    4'd6,
      env_coef:         16'd64989,
      onset_coef:       16'd65475,
      threshold_sq:     31'd33955,
      transitions_only: 1'b0
   };

   typedef struct packed {
      logic empty;
      logic room;   // space for at least two more entries
   } fifo_stat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_ACT,
      BK_DEC,
      BK_ERD,
      BK_EOUT
   } back_state_type;

endpackage

[sv/saod_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module saod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/saod_fifo.sv]
// Short job queue between the sample front end and the channel update engine.
module saod_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = saod_pkg::FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output saod_pkg::fifo_stat_type stat
);

   import saod_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.room  = (count_ff <= CNT_W'(DEPTH - 2));

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)) || pop)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job queue underflow");
`endif

endmodule

[sv/saod_front.sv]
// Front end: squares samples, sums each channel block and queues finished blocks.
module saod_front #(
   parameter int MAX_CHANNELS = saod_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [saod_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  saod_pkg::cfg_type                    cfg,
   input  saod_pkg::fifo_stat_type              fifo_stat,
   output logic                                 push,
   output logic [saod_pkg::MS_W + 2 * ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0]
                                                push_data
);

   import saod_pkg::*;

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             sq_vld_ff;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_nxt, sum_shr;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_nxt, blk_len;
   logic [CH_W-1:0]  ch_now_ff, ch_now_in;

   logic signed [SAMPLE_W-1:0]   smp;
   logic signed [2*SAMPLE_W-1:0] smp_sq;
   logic                         accept;
   logic [LOG2_W-1:0]            k_eff;
   logic [CH_W-1:0]              nlast, ch;
   logic                         last, done;
   logic [MS_W-1:0]              ms;

   always_comb begin
      smp    = signed'(req_tdata[SAMPLE_W-1:0]);
      smp_sq = smp * smp;
      sq_in  = smp_sq[SQ_W-1:0];
      accept = req_tvalid && req_tready;

      k_eff = (cfg.frag_len_log2 > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2)
                                                      : cfg.frag_len_log2;
      if (cfg.channel_count == '0) begin
         nlast = '0;
      end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
         nlast = CH_W'(MAX_CHANNELS - 1);
      end else begin
         nlast = CH_W'(cfg.channel_count - 1'b1);
      end

      // a channel index past the current count is taken as the last one
      ch   = (ch_now_ff > nlast) ? nlast : ch_now_ff;
      last = (ch == nlast);

      cnt_nxt = cnt_ff + 1'b1;
      blk_len = CNT_W'(1) << k_eff;
      done    = (cnt_nxt >= blk_len);
      sum_nxt = sum_ff + SUM_W'(sq_ff);
      sum_shr = sum_nxt >> k_eff;
      ms      = sum_shr[MS_W-1:0];

      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      ch_now_in = ch_now_ff;
      push      = 1'b0;
      if (sq_vld_ff) begin
         if (done) begin
            push      = 1'b1;
            sum_in    = '0;
            cnt_in    = '0;
            ch_now_in = last ? '0 : CH_W'(ch + 1'b1);
         end else begin
            sum_in = sum_nxt;
            cnt_in = cnt_nxt;
         end
      end
      push_data = {ms, last, nlast, ch};
   end

   // two free queue slots cover the item still in the squaring stage
   assign req_tready = fifo_stat.room;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         ch_now_ff <= '0;
      end else begin
         sq_vld_ff <= accept;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
         ch_now_ff <= ch_now_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff <= sq_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_block_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < (CNT_W'(1) << MAX_LOG2))
      else $error("block sample count past the longest block");
`endif

endmodule

[sv/saod_back.sv]
// Back end: per-channel intensity, activity and onset update, and level reports.
module saod_back #(
   parameter int MAX_CHANNELS = saod_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  saod_pkg::cfg_type                    cfg,
   input  saod_pkg::fifo_stat_type              fifo_stat,
   output logic                                 pop,
   input  logic [saod_pkg::MS_W + 2 * ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0]
                                                pop_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [saod_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);

   import saod_pkg::*;

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int JOB_W  = MS_W + 1 + 2 * CH_W;
   localparam int ENT_W  = INT_W + DEC_W + 1 + LEVEL_W;
   localparam int INTF_W = ACC_W - 16;
   localparam int LEAK_W = DEC_W + 2;

   localparam logic [2:0] PP_AMS_LO = 3'd0;   // (1 - c) * ms, low part
   localparam logic [2:0] PP_AMS_HI = 3'd1;
   localparam logic [2:0] PP_CI_LO  = 3'd2;   // c * old intensity
   localparam logic [2:0] PP_CI_HI  = 3'd3;
   localparam logic [2:0] PP_GM_LO  = 3'd4;   // g * |decay|
   localparam logic [2:0] PP_GM_HI  = 3'd5;
   localparam logic [2:0] STEP_LAST = 3'(STEPS);

   localparam logic signed [LEAK_W-1:0] LEAK_MAX =
      {{(LEAK_W - DEC_W + 1){1'b0}}, {(DEC_W - 1){1'b1}}};
   localparam logic signed [LEAK_W-1:0] LEAK_MIN =
      {{(LEAK_W - DEC_W + 1){1'b1}}, {(DEC_W - 1){1'b0}}};
   localparam logic signed [LEAK_W-1:0] UNIT      = LEAK_W'(65536);
   localparam logic signed [LEAK_W-1:0] ONSET_LIM = LEAK_W'(32768);

   back_state_type state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [CH_W-1:0]   nlast_ff, nlast_in;
   logic              last_ff, last_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic              ent_vld_ff, ent_vld_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_int_ff, acc_int_in;
   logic [ACC_W-1:0]  acc_dec_ff, acc_dec_in;
   logic [DEC_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic              act_ff, act_in;
   logic [INT_W-1:0]  inten_ff, inten_in;
   logic              changed_ff, changed_in;
   logic [CH_W-1:0]   emit_ff, emit_in;
   logic              lvl_vld_ff, lvl_vld_in;
   logic [MAX_CHANNELS-1:0] vld_ff, vld_in;

   logic [ENT_W-1:0]   ent_q, ent, ent_wdata;
   logic [INT_W-1:0]   ent_int;
   logic [DEC_W-1:0]   ent_dec;
   logic               ent_prev;
   logic [LEVEL_W-1:0] ent_lvl;
   logic               ent_rd_en, wr_en, lvl_rd_en;
   logic [CH_W-1:0]    job_ch;
   logic [LEVEL_W-1:0] lvl_q, lvl_out, lvl_new;

   logic [MULA_W-1:0]  mul_a, cc;
   logic [MULB_W-1:0]  mul_b;
   logic [2:0]         prev_step;
   logic [ACC_W-1:0]   sh_prod;
   logic [INTF_W-1:0]  inten_full;
   logic [DEC_W-1:0]   lk;
   logic signed [LEAK_W-1:0] lk_s, leak, leak_sat;
   logic               chg;

   saod_ram #(.WIDTH(ENT_W), .DEPTH(MAX_CHANNELS)) u_chan_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ch_ff),
      .wr_data (ent_wdata),
      .rd_en   (ent_rd_en),
      .rd_addr (job_ch),
      .rd_data (ent_q)
   );

   saod_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_CHANNELS)) u_level_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ch_ff),
      .wr_data (lvl_new),
      .rd_en   (lvl_rd_en),
      .rd_addr (emit_ff),
      .rd_data (lvl_q)
   );

   always_comb begin
      // entries never written read as the reset value
      ent      = ent_vld_ff ? ent_q : '0;
      ent_int  = ent[ENT_W-1 -: INT_W];
      ent_dec  = ent[LEVEL_W + 1 +: DEC_W];
      ent_prev = ent[LEVEL_W];
      ent_lvl  = ent[LEVEL_W-1:0];
      job_ch   = pop_data[CH_W-1:0];
      lvl_out  = lvl_vld_ff ? lvl_q : LEVEL_SILENT;

      cc = MULA_W'(17'h10000 - {1'b0, cfg.env_coef});
      case (step_ff)
         PP_AMS_LO: begin
            mul_a = cc;
            mul_b = ms_ff[MULB_W-1:0];
         end
         PP_AMS_HI: begin
            mul_a = cc;
            mul_b = MULB_W'(ms_ff[MS_W-1:MULB_W]);
         end
         PP_CI_LO: begin
            mul_a = {1'b0, cfg.env_coef};
            mul_b = ent_int[MULB_W-1:0];
         end
         PP_CI_HI: begin
            mul_a = {1'b0, cfg.env_coef};
            mul_b = MULB_W'(ent_int[INT_W-1:MULB_W]);
         end
         PP_GM_LO: begin
            mul_a = {1'b0, cfg.onset_coef};
            mul_b = mag_ff[MULB_W-1:0];
         end
         PP_GM_HI: begin
            mul_a = {1'b0, cfg.onset_coef};
            mul_b = MULB_W'(mag_ff[DEC_W-1:MULB_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prev_step = step_ff - 1'b1;
      sh_prod   = prev_step[0] ? ACC_W'({prod_ff, {MULB_W{1'b0}}}) : ACC_W'(prod_ff);

      inten_full = acc_int_ff[ACC_W-1:16];
      lk         = acc_dec_ff[16 +: DEC_W];
      lk_s       = $signed({2'b00, lk});
      leak       = neg_ff ? -lk_s : lk_s;
      if (act_ff && !ent_prev) begin
         leak = leak + UNIT;
      end else if (!act_ff && ent_prev) begin
         leak = leak - UNIT;
      end
      if (leak > LEAK_MAX) begin
         leak_sat = LEAK_MAX;
      end else if (leak < LEAK_MIN) begin
         leak_sat = LEAK_MIN;
      end else begin
         leak_sat = leak;
      end
      if (!act_ff) begin
         lvl_new = LEVEL_SILENT;
      end else if (leak_sat > ONSET_LIM) begin
         lvl_new = LEVEL_ONSET;
      end else begin
         lvl_new = LEVEL_ACTIVE;
      end
      ent_wdata = {inten_ff, leak_sat[DEC_W-1:0], act_ff, lvl_new};
      chg       = changed_ff || (lvl_new != ent_lvl);

      state_in   = state_ff;
      step_in    = step_ff;
      ch_in      = ch_ff;
      nlast_in   = nlast_ff;
      last_in    = last_ff;
      ms_in      = ms_ff;
      ent_vld_in = ent_vld_ff;
      prod_in    = prod_ff;
      acc_int_in = acc_int_ff;
      acc_dec_in = acc_dec_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      act_in     = act_ff;
      inten_in   = inten_ff;
      changed_in = changed_ff;
      emit_in    = emit_ff;
      lvl_vld_in = lvl_vld_ff;
      vld_in     = vld_ff;
      pop        = 1'b0;
      ent_rd_en  = 1'b0;
      lvl_rd_en  = 1'b0;
      wr_en      = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!fifo_stat.empty) begin
               pop        = 1'b1;
               ent_rd_en  = 1'b1;
               ent_vld_in = vld_ff[job_ch];
               ch_in      = job_ch;
               nlast_in   = pop_data[2*CH_W-1:CH_W];
               last_in    = pop_data[2*CH_W];
               ms_in      = pop_data[JOB_W-1 -: MS_W];
               acc_int_in = '0;
               acc_dec_in = '0;
               step_in    = '0;
               state_in   = BK_MUL;
            end
         end
         BK_MUL: begin
            // one partial product issued and the previous one summed per cycle
            if (step_ff == PP_AMS_LO) begin
               neg_in = ent_dec[DEC_W-1];
               mag_in = ent_dec[DEC_W-1] ? (~ent_dec + 1'b1) : ent_dec;
            end
            if (step_ff != STEP_LAST) begin
               prod_in = mul_a * mul_b;
            end
            if (step_ff != PP_AMS_LO) begin
               if (prev_step < PP_GM_LO) begin
                  acc_int_in = acc_int_ff + sh_prod;
               end else begin
                  acc_dec_in = acc_dec_ff + sh_prod;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = BK_ACT;
            end
         end
         BK_ACT: begin
            act_in   = (inten_full > INTF_W'(cfg.threshold_sq));
            inten_in = inten_full[INT_W-1:0];
            state_in = BK_DEC;
         end
         BK_DEC: begin
            wr_en         = 1'b1;
            vld_in[ch_ff] = 1'b1;
            if (last_ff) begin
               changed_in = 1'b0;
               emit_in    = '0;
               state_in   = (!cfg.transitions_only || chg) ? BK_ERD : BK_IDLE;
            end else begin
               changed_in = chg;
               state_in   = BK_IDLE;
            end
         end
         BK_ERD: begin
            lvl_rd_en  = 1'b1;
            lvl_vld_in = vld_ff[emit_ff];
            state_in   = BK_EOUT;
         end
         BK_EOUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (emit_ff == nlast_ff) begin
                  state_in = BK_IDLE;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  state_in = BK_ERD;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_tdata = RSP_TDATA_W'({lvl_out, CHAN_W'(emit_ff)});
   assign rsp_tlast = (emit_ff == nlast_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         changed_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         changed_ff <= changed_in;
         vld_ff     <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      ch_ff      <= ch_in;
      nlast_ff   <= nlast_in;
      last_ff    <= last_in;
      ms_ff      <= ms_in;
      ent_vld_ff <= ent_vld_in;
      prod_ff    <= prod_in;
      acc_int_ff <= acc_int_in;
      acc_dec_ff <= acc_dec_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      act_ff     <= act_in;
      inten_ff   <= inten_in;
      emit_ff    <= emit_in;
      lvl_vld_ff <= lvl_vld_in;
   end

`ifndef NO_ASSERTIONS
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> emit_ff <= nlast_ff)
      else $error("report index past the last channel");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_MUL |-> step_ff <= STEP_LAST)
      else $error("multiply step out of range");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == BK_MUL && step_ff == PP_AMS_LO)
      else $error("job taken without starting the update");
`endif

endmodule

[sv/speech_activity_onset_detector.sv]
// Top level of the speech activity onset detector: registers, front, queue, back.
// Data path: each taken sample is squared into a register before it is added to the
// block sum; a completed channel block passes through the update engine as a queue
// read, six partial products on one shared 17x24 multiplier, and intensity and decay
// steps; each level report is then read through the registered read of the level memory.
// Throughput: one sample per cycle while the four-entry job queue has two free slots.
// Reset is synchronous; channel stores read as zero through per-channel valid bits.
module speech_activity_onset_detector #(
   parameter int MAX_CHANNELS = saod_pkg::MAX_CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [saod_pkg::REQ_TDATA_W-1:0]   req_tdata,    // [15:0] sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [saod_pkg::RSP_TDATA_W-1:0]   rsp_tdata,    // [2:0] channel, [4:3] level
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [saod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [saod_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import saod_pkg::*;

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int JOB_W = MS_W + 1 + 2 * CH_W;

   cfg_type       cfg_ff, cfg_in;
   fifo_stat_type fifo_stat;
   logic             push, pop;
   logic [JOB_W-1:0] push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CHANNEL_COUNT:    cfg_in.channel_count    = csr_wr_data[CNT_CFG_W-1:0];
            CSR_FRAG_LEN_LOG2:    cfg_in.frag_len_log2    = csr_wr_data[LOG2_W-1:0];
            CSR_ENV_COEF:         cfg_in.env_coef         = csr_wr_data[COEF_W-1:0];
            CSR_ONSET_COEF:       cfg_in.onset_coef       = csr_wr_data[COEF_W-1:0];
            CSR_THRESHOLD_SQ:     cfg_in.threshold_sq     = csr_wr_data[THR_W-1:0];
            CSR_TRANSITIONS_ONLY: cfg_in.transitions_only = csr_wr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   saod_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .push_data  (push_data)
   );

   saod_fifo #(.WIDTH(JOB_W), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   saod_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_stat  (fifo_stat),
      .pop        (pop),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
